/* rtl/hcf_pkg.sv */
// Shared types and constants for the handshake connection state machine.
// Used by hcf_ctrl and handshake_connection_fsm_core; no dependencies.
package hcf_pkg;

    // Field and register widths
    localparam int CFG_W        = 16;
    localparam int TIMER_W      = 17;
    localparam int PKT_SEQ_W    = 16;
    localparam int SEQ_BITS_DEF = 16;
    localparam int OPEN_EXTRA_DEF = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_SEQ     = 2'd0;
    localparam logic [1:0] CFG_ADV_WINDOW    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Received packet types that are answered
    localparam logic [2:0] RX_SYNACK = 3'd1;
    localparam logic [2:0] RX_FINACK = 3'd4;

    typedef enum logic [2:0] {
        ST_CLOSED      = 3'd0,
        ST_WAIT_SYNACK = 3'd1,
        ST_WAIT_OPEN   = 3'd2,
        ST_ESTABLISHED = 3'd3,
        ST_WAIT_FINACK = 3'd4,
        ST_WAIT_CLOSE  = 3'd5
    } conn_state_t;

    typedef enum logic [1:0] {
        EV_TICK   = 2'd0,
        EV_OPEN   = 2'd1,
        EV_CLOSE  = 2'd2,
        EV_PACKET = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        TX_SYN = 2'd0,
        TX_ACK = 2'd1,
        TX_FIN = 2'd2
    } tx_type_t;

    typedef enum logic [2:0] {
        STS_NONE   = 3'd0,
        STS_ACCEPT = 3'd1,
        STS_REJECT = 3'd2,
        STS_RESEND = 3'd3,
        STS_DONE   = 3'd4
    } status_t;

    typedef struct packed {
        event_kind_t            func;
        logic [2:0]             pkt_type;
        logic [PKT_SEQ_W-1:0]   pkt_seq;
        logic                   pkt_checksum_ok;
    } event_t;

    typedef struct packed {
        logic                   send_valid;
        tx_type_t               send_type;
        logic [PKT_SEQ_W-1:0]   send_seq;
        logic [CFG_W-1:0]       send_window;
        conn_state_t            link_state;
        status_t                status;
    } result_t;

endpackage

/* rtl/hcf_ctrl.sv */
// Connection state, sequence number and timeout counter with the per-event
// update logic. Depends on hcf_pkg.
module hcf_ctrl import hcf_pkg::*; #(
    parameter int SEQ_BITS         = SEQ_BITS_DEF,
    parameter int OPEN_EXTRA_TICKS = OPEN_EXTRA_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  event_t           ev,
    input  logic [CFG_W-1:0] start_seq,
    input  logic [CFG_W-1:0] adv_window,
    input  logic [CFG_W-1:0] timeout_ticks,
    output result_t          res
);

    localparam int CMP_W = (SEQ_BITS > PKT_SEQ_W) ? SEQ_BITS : PKT_SEQ_W;
    localparam logic [TIMER_W-1:0] OPEN_EXTRA = TIMER_W'(8'(OPEN_EXTRA_TICKS));

    conn_state_t          state_reg, state_next;
    logic [SEQ_BITS-1:0]  seq_reg, seq_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic                 armed_reg, armed_next;

    logic [TIMER_W-1:0]   load_base;
    logic [TIMER_W-1:0]   load_open;
    logic [SEQ_BITS-1:0]  seq_inc;
    logic                 tick_fire;
    logic                 waiting_reply;
    logic                 reply_match;
    logic                 send_valid;
    tx_type_t             send_type;
    status_t              status;

    // Shared decode
    assign load_base     = TIMER_W'(timeout_ticks);
    assign load_open     = TIMER_W'(timeout_ticks) + OPEN_EXTRA;
    assign seq_inc       = seq_reg + SEQ_BITS'(1);
    assign tick_fire     = armed_reg && (timer_reg <= TIMER_W'(1));
    assign waiting_reply = (state_reg == ST_WAIT_SYNACK) || (state_reg == ST_WAIT_FINACK);
    assign reply_match   = (ev.pkt_type == ((state_reg == ST_WAIT_SYNACK) ? RX_SYNACK : RX_FINACK))
                        && (CMP_W'(ev.pkt_seq) == CMP_W'(seq_reg))
                        && ev.pkt_checksum_ok;

    // Next state, sequence number and timer
    always_comb begin
        state_next = state_reg;
        seq_next   = seq_reg;
        timer_next = timer_reg;
        armed_next = armed_reg;
        case (ev.func)
            EV_TICK: begin
                if (armed_reg) begin
                    if (!tick_fire) begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end else if (waiting_reply) begin
                        timer_next = load_base;
                    end else begin
                        armed_next = 1'b0;
                        timer_next = '0;
                        if (state_reg == ST_WAIT_OPEN) begin
                            state_next = ST_ESTABLISHED;
                            seq_next   = seq_inc;
                        end else if (state_reg == ST_WAIT_CLOSE) begin
                            state_next = ST_CLOSED;
                            seq_next   = seq_inc;
                        end
                    end
                end
            end
            EV_OPEN: begin
                if (state_reg == ST_CLOSED) begin
                    state_next = ST_WAIT_SYNACK;
                    seq_next   = SEQ_BITS'(start_seq);
                    timer_next = load_base;
                    armed_next = 1'b1;
                end
            end
            EV_CLOSE: begin
                if (state_reg == ST_ESTABLISHED) begin
                    state_next = ST_WAIT_FINACK;
                    timer_next = load_base;
                    armed_next = 1'b1;
                end
            end
            EV_PACKET: begin
                if (waiting_reply && reply_match) begin
                    seq_next   = seq_inc;
                    armed_next = 1'b1;
                    if (state_reg == ST_WAIT_SYNACK) begin
                        state_next = ST_WAIT_OPEN;
                        timer_next = load_open;
                    end else begin
                        state_next = ST_WAIT_CLOSE;
                        timer_next = load_base;
                    end
                end else if ((state_reg == ST_WAIT_OPEN) || (state_reg == ST_WAIT_CLOSE)) begin
                    timer_next = load_base;
                    armed_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Packet to send and status for this event
    always_comb begin
        send_valid = 1'b0;
        send_type  = TX_SYN;
        status     = STS_NONE;
        case (ev.func)
            EV_TICK: begin
                if (tick_fire) begin
                    if (waiting_reply) begin
                        send_valid = 1'b1;
                        send_type  = (state_reg == ST_WAIT_SYNACK) ? TX_SYN : TX_FIN;
                        status     = STS_RESEND;
                    end else if ((state_reg == ST_WAIT_OPEN) || (state_reg == ST_WAIT_CLOSE)) begin
                        status = STS_DONE;
                    end
                end
            end
            EV_OPEN: begin
                if (state_reg == ST_CLOSED) begin
                    send_valid = 1'b1;
                    send_type  = TX_SYN;
                end
            end
            EV_CLOSE: begin
                if (state_reg == ST_ESTABLISHED) begin
                    send_valid = 1'b1;
                    send_type  = TX_FIN;
                end
            end
            EV_PACKET: begin
                if (waiting_reply) begin
                    if (reply_match) begin
                        send_valid = 1'b1;
                        send_type  = TX_ACK;
                        status     = STS_ACCEPT;
                    end else begin
                        status = STS_REJECT;
                    end
                end else if ((state_reg == ST_WAIT_OPEN) || (state_reg == ST_WAIT_CLOSE)) begin
                    send_valid = 1'b1;
                    send_type  = TX_ACK;
                end
            end
            default: ;
        endcase
    end

    // Result fields; payload zeroed when nothing is sent
    always_comb begin
        res.send_valid  = send_valid;
        res.send_type   = send_type;
        res.send_seq    = send_valid ? PKT_SEQ_W'(seq_next) : '0;
        res.send_window = send_valid ? adv_window : '0;
        res.link_state  = state_next;
        res.status      = status;
    end

    // Advance state once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLOSED;
            seq_reg   <= '0;
            timer_reg <= '0;
            armed_reg <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            timer_reg <= timer_next;
            armed_reg <= armed_next;
        end
    end

endmodule

/* rtl/handshake_connection_fsm_core.sv */
// Sender side of a connect / teardown handshake: input register, state update
// and result register. Depends on hcf_pkg and hcf_ctrl.
// An event passes through the input register, then the result register.
// Throughput: one event per cycle while the result side keeps taking results; the
// state update is a single compare-and-increment step between the two registers.
// Reset (aresetn low, synchronous): state closed, sequence number 0, timer
// disarmed, both stages empty, registers back to start_seq 5, window 16, timeout 1000.
module handshake_connection_fsm_core import hcf_pkg::*; #(
    parameter int SEQ_BITS         = SEQ_BITS_DEF,
    parameter int OPEN_EXTRA_TICKS = OPEN_EXTRA_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Input event channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // pkt_type[2:0], pkt_seq[18:3], pkt_checksum_ok[19]
    input  logic [1:0]       s_tuser,   // func[1:0]
    // Result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // send_valid[0], send_type[2:1], send_seq[18:3],
                                        // send_window[34:19], link_state[37:35], status[40:38]
    // Configuration write port
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CFG_W-1:0] start_seq_reg;
    logic [CFG_W-1:0] adv_window_reg;
    logic [CFG_W-1:0] timeout_ticks_reg;

    logic             in_valid_reg;
    event_t           in_item_reg;
    logic             out_valid_reg;
    result_t          out_item_reg;

    event_t           ev_in;
    result_t          step_res;
    logic             advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seq_reg     <= CFG_W'(5);
            adv_window_reg    <= CFG_W'(16);
            timeout_ticks_reg <= CFG_W'(1000);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_SEQ:     start_seq_reg     <= cfg_wdata;
                CFG_ADV_WINDOW:    adv_window_reg    <= cfg_wdata;
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Unpack the incoming transaction
    always_comb begin
        ev_in.func            = event_kind_t'(s_tuser);
        ev_in.pkt_type        = s_tdata[2:0];
        ev_in.pkt_seq         = s_tdata[18:3];
        ev_in.pkt_checksum_ok = s_tdata[19];
    end

    // Move the held event forward when the result register is empty or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= ev_in;
        end
    end

    hcf_ctrl #(
        .SEQ_BITS         (SEQ_BITS),
        .OPEN_EXTRA_TICKS (OPEN_EXTRA_TICKS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .ev            (in_item_reg),
        .start_seq     (start_seq_reg),
        .adv_window    (adv_window_reg),
        .timeout_ticks (timeout_ticks_reg),
        .res           (step_res)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_item_reg.status,
                       out_item_reg.link_state,
                       out_item_reg.send_window,
                       out_item_reg.send_seq,
                       out_item_reg.send_type,
                       out_item_reg.send_valid};

`ifndef SYNTHESIS
    // An event that moves forward always produces a result next cycle
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced event produced no result");

    // A held event that cannot move stays held
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled input event lost");

    // An accepted reply always sends an ACK
    a_accept_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_item_reg.status == STS_ACCEPT))
            |-> (out_item_reg.send_valid && (out_item_reg.send_type == TX_ACK)))
        else $error("accepted reply without ACK");

    // Nothing sent means empty packet fields
    a_idle_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_item_reg.send_valid)
            |-> ((out_item_reg.send_seq == '0) && (out_item_reg.send_window == '0)))
        else $error("payload set without a send");
`endif

endmodule

/* verif/handshake_connection_fsm_checker.sv */
// Checker for handshake_connection_fsm_core: watches the event, result and configuration ports,
// predicts each link result and compares it field by field with what the block sends.
// Depends on hcf_pkg for the event, state and result types.
module handshake_connection_fsm_checker import hcf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [23:0]      s_tdata,   // pkt_type[2:0], pkt_seq[18:3], pkt_checksum_ok[19]
    input  logic [1:0]       s_tuser,   // func[1:0]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [47:0]      m_tdata,   // send_valid[0], send_type[2:1], send_seq[18:3],
                                        // send_window[34:19], link_state[37:35], status[40:38]
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               pending,
    output conn_state_t      link_now,
    output logic [15:0]      seq_now
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam int OPEN_EXTRA   = OPEN_EXTRA_DEF;

    // Register copies, loaded with the reset values of the block
    logic [CFG_W-1:0]    start_seq_r;
    logic [CFG_W-1:0]    window_r;
    logic [CFG_W-1:0]    timeout_r;

    // Predicted connection state
    conn_state_t         conn;
    logic [15:0]         seq_num;
    logic [TIMER_W-1:0]  countdown;
    logic                armed;

    result_t             link_result_q[$];
    int                  failures = 0;

    // Build a result that carries a packet of the given kind
    function automatic result_t outgoing(tx_type_t kind);
        result_t r;
        r = '0;
        r.send_valid  = 1'b1;
        r.send_type   = kind;
        r.send_seq    = seq_num;
        r.send_window = window_r;
        return r;
    endfunction

    function automatic void load_countdown(int extra);
        countdown = TIMER_W'(timeout_r) + TIMER_W'(extra);
        armed     = 1'b1;
    endfunction

    // Apply one event to the connection state and return the result it causes
    function automatic result_t advance_link(event_t ev);
        result_t    r;
        status_t    sts;
        logic [2:0] wanted;
        r   = '0;
        sts = STS_NONE;
        case (ev.func)
            EV_TICK: begin
                if (armed) begin
                    if (countdown > 1) begin
                        countdown = countdown - 1'b1;
                    end else if (conn == ST_WAIT_SYNACK || conn == ST_WAIT_FINACK) begin
                        // retransmit the opening or closing packet
                        r = outgoing(conn == ST_WAIT_SYNACK ? TX_SYN : TX_FIN);
                        load_countdown(0);
                        sts = STS_RESEND;
                    end else if (conn == ST_WAIT_OPEN || conn == ST_WAIT_CLOSE) begin
                        // waiting state completes
                        conn      = (conn == ST_WAIT_OPEN) ? ST_ESTABLISHED : ST_CLOSED;
                        seq_num   = seq_num + 1'b1;
                        armed     = 1'b0;
                        countdown = '0;
                        sts       = STS_DONE;
                    end else begin
                        armed     = 1'b0;
                        countdown = '0;
                    end
                end
            end
            EV_OPEN: begin
                if (conn == ST_CLOSED) begin
                    seq_num = start_seq_r;
                    r       = outgoing(TX_SYN);
                    conn    = ST_WAIT_SYNACK;
                    load_countdown(0);
                end
            end
            EV_CLOSE: begin
                if (conn == ST_ESTABLISHED) begin
                    r    = outgoing(TX_FIN);
                    conn = ST_WAIT_FINACK;
                    load_countdown(0);
                end
            end
            EV_PACKET: begin
                if (conn == ST_WAIT_SYNACK || conn == ST_WAIT_FINACK) begin
                    wanted = (conn == ST_WAIT_SYNACK) ? RX_SYNACK : RX_FINACK;
                    if (ev.pkt_type == wanted && ev.pkt_seq == seq_num && ev.pkt_checksum_ok) begin
                        seq_num = seq_num + 1'b1;
                        r       = outgoing(TX_ACK);
                        if (conn == ST_WAIT_SYNACK) begin
                            conn = ST_WAIT_OPEN;
                            load_countdown(OPEN_EXTRA);
                        end else begin
                            conn = ST_WAIT_CLOSE;
                            load_countdown(0);
                        end
                        sts = STS_ACCEPT;
                    end else begin
                        sts = STS_REJECT;
                    end
                end else if (conn == ST_WAIT_OPEN || conn == ST_WAIT_CLOSE) begin
                    // any arrival repeats the ACK and restarts the timer
                    r = outgoing(TX_ACK);
                    load_countdown(0);
                end
            end
            default: ;
        endcase
        r.link_state = conn;
        r.status     = sts;
        return r;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("valid=%0d type=%0d seq=%0d win=%0d state=%0d status=%0d",
                         r.send_valid, r.send_type, r.send_seq, r.send_window,
                         r.link_state, r.status);
    endfunction

    always @(posedge aclk) begin
        event_t  arrived;
        result_t got;
        result_t want;
        if (!aresetn) begin
            start_seq_r = 16'd5;
            window_r    = 16'd16;
            timeout_r   = 16'd1000;
            conn        = ST_CLOSED;
            seq_num     = '0;
            countdown   = '0;
            armed       = 1'b0;
            link_result_q.delete();
        end else begin
            // track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_START_SEQ:     start_seq_r = cfg_wdata;
                    CFG_ADV_WINDOW:    window_r    = cfg_wdata;
                    CFG_TIMEOUT_TICKS: timeout_r   = cfg_wdata;
                    default: ;
                endcase
            end

            // predict on each accepted event transaction
            if (s_tvalid && s_tready) begin
                arrived.func            = event_kind_t'(s_tuser);
                arrived.pkt_type        = s_tdata[2:0];
                arrived.pkt_seq         = s_tdata[18:3];
                arrived.pkt_checksum_ok = s_tdata[19];
                link_result_q.push_back(advance_link(arrived));
            end

            // compare each accepted result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.send_valid  = m_tdata[0];
                got.send_type   = tx_type_t'(m_tdata[2:1]);
                got.send_seq    = m_tdata[18:3];
                got.send_window = m_tdata[34:19];
                got.link_state  = conn_state_t'(m_tdata[37:35]);
                got.status      = status_t'(m_tdata[40:38]);
                if (link_result_q.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: unexpected result %s", $realtime, show(got));
                end else begin
                    want = link_result_q.pop_front();
                    if (got.send_valid  !== want.send_valid  ||
                        got.send_type   !== want.send_type   ||
                        got.send_seq    !== want.send_seq    ||
                        got.send_window !== want.send_window ||
                        got.link_state  !== want.link_state  ||
                        got.status      !== want.status) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("%0t: mismatch, expected %s, got %s",
                                     $realtime, show(want), show(got));
                    end
                end
            end
        end
        fail_count <= failures;
        pending    <= link_result_q.size();
        link_now   <= conn;
        seq_now    <= seq_num;
    end

endmodule

/* verif/handshake_connection_fsm_core_test.sv */
// Top of the handshake_connection_fsm_core testbench: clock, reset, event stimulus,
// result back-pressure, register phases and the verdict. Depends on hcf_pkg,
// the block and handshake_connection_fsm_checker.
module handshake_connection_fsm_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hcf_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int END_CYCLES      = 10;
    localparam int PHASES          = 9;
    localparam int PHASE_ITEMS     = 120;
    localparam int SLOW_ITEMS      = 40;
    localparam int BURST_ITEMS     = 60;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;   // pkt_type[2:0], pkt_seq[18:3], pkt_checksum_ok[19]
    logic [1:0]       s_tuser;   // func[1:0]
    logic             m_tvalid;
    logic             m_tready;
    logic [47:0]      m_tdata;   // send_valid[0], send_type[2:1], send_seq[18:3],
                                 // send_window[34:19], link_state[37:35], status[40:38]
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int               fail_count;
    int               pending;
    conn_state_t      link_now;
    logic [15:0]      seq_now;

    bit               offering;
    bit               gapless;
    bit               stall_req;
    bit               stall_taken;
    int               idle_cycles;

    always #(HALF_PERIOD) aclk = ~aclk;

    handshake_connection_fsm_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    handshake_connection_fsm_checker link_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .link_now   (link_now),
        .seq_now    (seq_now)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one event and hold it until the block takes the transaction
    task automatic offer_event(event_kind_t kind, logic [2:0] ptype, logic [15:0] pseq,
                               logic ok);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, ok, pseq, ptype};
        offering = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid for a while and scramble the data lines meanwhile
    task automatic pause(int cycles);
        if (cycles > 0) begin
            if (offering) s_tvalid <= 1'b0;
            offering = 1'b0;
            s_tdata  <= {4'b0, 20'($urandom)};
            s_tuser  <= 2'($urandom);
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Let the checker catch up with the last accepted event
    task automatic settle();
        if (offering) pause(1);
    endtask

    // Drain the block, then write all three registers
    task automatic reconfigure(logic [CFG_W-1:0] start, logic [CFG_W-1:0] window,
                               logic [CFG_W-1:0] ticks);
        settle();
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_SEQ;
        cfg_wdata <= start;
        @(posedge aclk);
        cfg_index <= CFG_ADV_WINDOW;
        cfg_wdata <= window;
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_packet();
        offer_event(EV_PACKET, 3'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Pick the next event from the predicted state; fresh forces an exact reply
    task automatic random_event(bit fresh);
        int          roll;
        int          flaw;
        conn_state_t st;
        logic [2:0]  wanted;
        logic [2:0]  ptype;
        roll = $urandom_range(99);
        st   = link_now;
        if (roll < 10) begin
            offer_event(event_kind_t'($urandom_range(3)), 3'($urandom), 16'($urandom),
                        1'($urandom));
        end else begin
            case (st)
                ST_CLOSED: begin
                    if (roll < 70) offer_event(EV_OPEN, 3'($urandom), 16'($urandom), 1'b1);
                    else if (roll < 85) offer_event(EV_TICK, '0, '0, 1'b0);
                    else if (roll < 93) random_packet();
                    else offer_event(EV_CLOSE, '0, '0, 1'b0);
                end
                ST_WAIT_SYNACK, ST_WAIT_FINACK: begin
                    if (roll < 40) begin
                        // well-formed reply to the packet in flight
                        if (fresh) settle();
                        st     = link_now;
                        wanted = (st == ST_WAIT_SYNACK) ? RX_SYNACK : RX_FINACK;
                        if (st == ST_WAIT_SYNACK || st == ST_WAIT_FINACK)
                            offer_event(EV_PACKET, wanted, seq_now, 1'b1);
                        else
                            offer_event(EV_TICK, '0, '0, 1'b0);
                    end else if (roll < 58) begin
                        // broken reply: one flaw at a time
                        wanted = (st == ST_WAIT_SYNACK) ? RX_SYNACK : RX_FINACK;
                        flaw   = $urandom_range(2);
                        ptype  = 3'($urandom);
                        if (ptype == wanted) ptype = ptype + 3'd1;
                        if (flaw == 0)
                            offer_event(EV_PACKET, ptype, seq_now, 1'b1);
                        else if (flaw == 1)
                            offer_event(EV_PACKET, wanted,
                                        seq_now + 16'($urandom_range(1, 65535)), 1'b1);
                        else
                            offer_event(EV_PACKET, wanted, seq_now, 1'b0);
                    end else if (roll < 95) begin
                        offer_event(EV_TICK, '0, '0, 1'b0);
                    end else begin
                        offer_event(roll[0] ? EV_OPEN : EV_CLOSE, '0, '0, 1'b0);
                    end
                end
                ST_WAIT_OPEN, ST_WAIT_CLOSE: begin
                    if (roll < 75) offer_event(EV_TICK, '0, '0, 1'b0);
                    else if (roll < 92) random_packet();
                    else offer_event(roll[0] ? EV_OPEN : EV_CLOSE, '0, '0, 1'b0);
                end
                default: begin
                    if (roll < 40) offer_event(EV_CLOSE, '0, '0, 1'b0);
                    else if (roll < 70) offer_event(EV_TICK, '0, '0, 1'b0);
                    else if (roll < 85) random_packet();
                    else offer_event(EV_OPEN, '0, '0, 1'b0);
                end
            endcase
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (stall_req && !stall_taken) begin
                stall_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(19) == 0) repeat ($urandom_range(100, 200)) @(posedge aclk);
            else repeat ($urandom_range(1, 30)) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Watchdog: give up when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL handshake_connection_fsm_core");
            $finish;
        end
    end

    initial begin
        int items;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= EV_TICK;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_START_SEQ;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        offering    = 1'b0;
        gapless     = 1'b0;
        stall_req   = 1'b0;
        stall_taken = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: ignored events while closed, then an open with rejects and the accepted reply
        offer_event(EV_TICK, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_CLOSE, 3'd7, 16'hFFFF, 1'b1);
        offer_event(EV_PACKET, RX_SYNACK, 16'h0000, 1'b1);
        offer_event(EV_OPEN, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_OPEN, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_PACKET, RX_SYNACK, 16'd6, 1'b1);
        offer_event(EV_PACKET, 3'd0, 16'd5, 1'b1);
        offer_event(EV_PACKET, RX_SYNACK, 16'd5, 1'b0);
        offer_event(EV_PACKET, RX_SYNACK, 16'd5, 1'b1);
        offer_event(EV_PACKET, 3'd7, 16'h0000, 1'b0);
        offer_event(EV_TICK, 3'd0, 16'h0000, 1'b0);

        // Shortest timeout takes effect at the next timer load
        reconfigure(16'hFFFF, 16'hFFFF, 16'd1);
        offer_event(EV_PACKET, 3'd5, 16'hFFFF, 1'b1);
        offer_event(EV_TICK, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_TICK, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_PACKET, RX_FINACK, 16'd7, 1'b1);
        offer_event(EV_CLOSE, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_TICK, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_PACKET, RX_FINACK, 16'd8, 1'b1);
        offer_event(EV_PACKET, RX_SYNACK, 16'd7, 1'b1);
        offer_event(EV_PACKET, RX_FINACK, 16'd7, 1'b1);
        offer_event(EV_TICK, 3'd0, 16'h0000, 1'b0);

        // Reopen at the top of the sequence space so the sequence number wraps to zero on the reply
        offer_event(EV_OPEN, 3'd0, 16'h0000, 1'b0);
        offer_event(EV_PACKET, RX_SYNACK, 16'hFFFF, 1'b1);
        repeat (3) offer_event(EV_TICK, 3'd0, 16'h0000, 1'b0);

        // Random phases, each with its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            items = PHASE_ITEMS;
            case (phase)
                0: reconfigure(16'd0, 16'd0, 16'd2);
                1: reconfigure(16'hFFFE, 16'hFFFF, 16'd1);
                2: begin
                    reconfigure(16'($urandom), 16'($urandom), 16'hFFFF);
                    items = SLOW_ITEMS;
                end
                default: reconfigure(16'($urandom), 16'($urandom), 16'($urandom_range(1, 8)));
            endcase
            gapless = (phase % 4 == 3);
            for (int n = 0; n < items; n++) begin
                if (phase == 4 && n == 20) begin
                    // hold off the result side and keep offering back to back
                    stall_req = 1'b1;
                    repeat (BURST_ITEMS) random_event(1'b0);
                end
                random_event(1'b1);
                if (!gapless) pause(pick_gap());
            end
        end

        // Wait for the last results, then watch for strays before the verdict
        settle();
        while (pending != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("PASS handshake_connection_fsm_core");
        else
            $display("FAIL handshake_connection_fsm_core");
        $finish;
    end

endmodule

/* filelist.f */
rtl/hcf_pkg.sv
rtl/hcf_ctrl.sv
rtl/handshake_connection_fsm_core.sv
verif/handshake_connection_fsm_checker.sv
verif/handshake_connection_fsm_core_test.sv
